>>> hdl/substring_search_index_after_macros.svh
// Assertion macros for the substring search block.
`ifndef SUBSTRING_SEARCH_INDEX_AFTER_MACROS_SVH
`define SUBSTRING_SEARCH_INDEX_AFTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SSIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssia: implication check failed");

`define SSIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssia: next-cycle check failed");

`else

`define SSIA_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define SSIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/ssia_pkg.sv
// Shared types, constants and functions for the substring search block.
`default_nettype none

package ssia_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_TEXT_DEF    = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_CFG_W  = 5;
    localparam int START_W    = 12;
    localparam int INDEX_W    = 13;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_SEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd4;

    typedef struct packed {
        logic [63:0]           pat_lo;
        logic [63:0]           pat_hi;
        logic [LEN_CFG_W-1:0]  pat_len;
        logic                  case_sens;
        logic [START_W-1:0]    start;
    } t_cfg;

    // Folds 'A'..'Z' to lower case unless the compare is exact.
    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic cs);
        logic [7:0] r;
        r = c;
        if (!cs && (c inside {[8'h41:8'h5A]})) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ssia_cfg.sv
// Configuration register file for the substring search block.
`default_nettype none

module ssia_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [ssia_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [ssia_pkg::CFG_DATA_W-1:0] i_wr_data,
    output ssia_pkg::t_cfg                       o_cfg
);
    import ssia_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_lo    <= '0;
            r_cfg.pat_hi    <= '0;
            r_cfg.pat_len   <= LEN_CFG_W'(1);
            r_cfg.case_sens <= 1'b1;
            r_cfg.start     <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_PAT_LO:   r_cfg.pat_lo    <= i_wr_data;
                REG_PAT_HI:   r_cfg.pat_hi    <= i_wr_data;
                REG_PAT_LEN:  r_cfg.pat_len   <= i_wr_data[LEN_CFG_W-1:0];
                REG_CASE_SEN: r_cfg.case_sens <= i_wr_data[0];
                REG_START:    r_cfg.start     <= i_wr_data[START_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hdl/ssia_match.sv
// Window compare: decides whether the pattern ends at the current byte.
`default_nettype none

module ssia_match #(
    parameter int MAX_PATTERN = ssia_pkg::MAX_PATTERN_DEF,
    parameter int POS_W       = 13,
    parameter int WIN_D       = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1
) (
    input  wire ssia_pkg::t_cfg          i_cfg,
    input  wire logic [7:0]              i_byte,
    input  wire logic [WIN_D-1:0][7:0]   i_window,
    input  wire logic [POS_W-1:0]        i_pos,
    output logic                         o_hit
);
    import ssia_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CMP_W = ((POS_W > START_W) ? POS_W : START_W) + 2;

    logic [MAX_PATTERN-1:0][7:0] pchar;
    logic [MAX_PATTERN-1:0][7:0] win;
    logic [MAX_PATTERN-1:0]      eq;
    logic [LEN_W-1:0]            len_eff;
    logic                        pos_ok;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_pchar
            if (g < 8) begin : g_lo
                assign pchar[g] = i_cfg.pat_lo[8*g +: 8];
            end else if (g < 16) begin : g_hi
                assign pchar[g] = i_cfg.pat_hi[8*(g-8) +: 8];
            end else begin : g_zero
                assign pchar[g] = 8'h00;
            end
            if (g == 0) begin : g_cur
                assign win[g] = i_byte;
            end else begin : g_old
                assign win[g] = i_window[g-1];
            end
        end
    endgenerate

    assign len_eff = (int'(i_cfg.pat_len) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                         : LEN_W'(i_cfg.pat_len);

    always_comb begin
        int back;
        back = 0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            back = int'(len_eff) - 1 - j;
            if (j < int'(len_eff)) begin
                eq[j] = fold_char(win[back[IDX_W-1:0]], i_cfg.case_sens)
                     == fold_char(pchar[j], i_cfg.case_sens);
            end else begin
                eq[j] = 1'b1;
            end
        end
    end

    // Match begins at pos+1-len; it must fit and start at or after the offset.
    assign pos_ok = (CMP_W'(i_pos) + CMP_W'(1)) >= (CMP_W'(len_eff) + CMP_W'(i_cfg.start));

    assign o_hit = (len_eff != '0) && pos_ok && (&eq);

endmodule

`default_nettype wire

>>> hdl/substring_search_index_after.sv
// Substring search top level: input register, window compare, result register.
// The result register loads when the input register passes on the byte that causes it.
// Throughput: one text byte per cycle while the result is not stalled; the compare is combinational.
// Input stall rises only while the input register holds a byte and the result is stalled.
// Reset (synchronous, active low) clears valid flags and position, sets config defaults.
`default_nettype none
`include "substring_search_index_after_macros.svh"

module substring_search_index_after #(
    parameter int MAX_PATTERN = ssia_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = ssia_pkg::MAX_TEXT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ssia_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssia_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [7:0]                      i_text_byte,
    input  wire logic                            i_end_of_text,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_found,
    output logic [ssia_pkg::INDEX_W-1:0]         o_index_after
);
    import ssia_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT + 1);
    localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    t_cfg                 cfg;
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic [WIN_D-1:0][7:0] r_window;
    logic [POS_W-1:0]     r_pos;
    logic                 r_matched;
    logic                 r_out_valid;
    logic                 r_found;
    logic [INDEX_W-1:0]   r_index;

    logic                 advance;
    logic                 fire;
    logic                 active;
    logic                 match_hit;
    logic                 hit;
    logic                 emit;
    logic [INDEX_W-1:0]   n_index;

    assign o_cfg_ready = 1'b1;

    ssia_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    ssia_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .POS_W       (POS_W),
        .WIN_D       (WIN_D)
    ) u_match (
        .i_cfg    (cfg),
        .i_byte   (r_in_byte),
        .i_window (r_window),
        .i_pos    (r_pos),
        .o_hit    (match_hit)
    );

    assign advance    = !(r_out_valid && i_out_stall);
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    assign active  = !r_matched && (r_pos < POS_W'(MAX_TEXT));
    assign hit     = active && match_hit;
    assign emit    = hit || (r_in_last && !r_matched);
    assign n_index = INDEX_W'(32'(r_pos) + 32'd1);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_end_of_text;
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_matched <= 1'b0;
        end else if (fire) begin
            if (r_in_last) begin
                r_pos     <= '0;
                r_matched <= 1'b0;
            end else begin
                if (active) begin
                    r_pos <= r_pos + POS_W'(1);
                end
                if (hit) begin
                    r_matched <= 1'b1;
                end
            end
        end
    end

    generate
        if (WIN_D > 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (fire && active) begin
                    r_window <= {r_window[WIN_D-2:0], r_in_byte};
                end
            end
        end else begin : g_single
            always_ff @(posedge i_clk) begin
                if (fire && active) begin
                    r_window[0] <= r_in_byte;
                end
            end
        end
    endgenerate

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit && advance) begin
            r_found <= hit;
            r_index <= hit ? n_index : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_index_after = r_index;

    `SSIA_ASSERT_IMPL(a_nf_zero_index, i_clk, i_rst_n, o_out_valid && !o_found, o_index_after == '0)
    `SSIA_ASSERT_IMPL(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(MAX_TEXT))
    `SSIA_ASSERT_NEXT(a_hit_marks, i_clk, i_rst_n, fire && hit && !r_in_last, r_matched)
    `SSIA_ASSERT_NEXT(a_pos_frozen, i_clk, i_rst_n, r_matched, (r_pos == $past(r_pos)) || (r_pos == '0))
    `SSIA_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)

endmodule

`default_nettype wire
